>>> src/tgadec_pkg.sv
// Shared types and constants for the TGA image stream decoder.
package tgadec_pkg;

	// result kinds carried on the master-side tuser
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// packed widths of the stream words
	localparam int unsigned IN_DATA_W  = 8;
	localparam int unsigned OUT_DATA_W = 80;

	// one decoded result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] width;
		logic [15:0] height;
		logic [2:0]  channels;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_res;
		logic        last;
	} result_t;

endpackage

>>> src/tgadec_parser.sv
// Header parse, skip, raw and RLE packet decode for one file byte per accept.
module tgadec_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          file_byte,
	input  logic                first,
	output logic                res_valid,
	output tgadec_pkg::result_t res
);
	import tgadec_pkg::*;

	// parse phases
	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_SKIP   = 3'd1;
	localparam logic [2:0] PH_RAW    = 3'd2;
	localparam logic [2:0] PH_PKT    = 3'd3;
	localparam logic [2:0] PH_PIX    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;
	localparam logic [2:0] PH_ERR    = 3'd6;

	localparam logic [4:0] HDR_ID_LEN = 5'd0;
	localparam logic [4:0] HDR_TYPE   = 5'd2;
	localparam logic [4:0] HDR_W_LO   = 5'd12;
	localparam logic [4:0] HDR_W_HI   = 5'd13;
	localparam logic [4:0] HDR_H_LO   = 5'd14;
	localparam logic [4:0] HDR_H_HI   = 5'd15;
	localparam logic [4:0] HDR_DEPTH  = 5'd16;

	localparam logic [7:0] TYPE_RLE = 8'd10;
	localparam logic [7:0] DEPTH_16 = 8'd16;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	logic [2:0]  phase_q;
	logic [4:0]  hidx_q;
	logic [7:0]  id_len_q;
	logic [7:0]  type_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [7:0]  depth_q;
	logic [8:0]  skip_q;
	logic [31:0] pix_left_q;
	logic [7:0]  pkt_left_q;
	logic        is_run_q;
	logic [31:0] col_q;
	logic [1:0]  cidx_q;

	// state as seen by this byte (a first byte restarts from reset)
	logic [2:0]  ph;
	logic [4:0]  hidx;
	logic [7:0]  id_len;
	logic [7:0]  img_type;
	logic [15:0] w;
	logic [15:0] h;
	logic [7:0]  depth;
	logic [8:0]  skip;
	logic [31:0] pix_left;
	logic [7:0]  pkt_left;
	logic        is_run;
	logic [1:0]  cidx;

	logic [2:0]  ph_n;
	logic [4:0]  hidx_n;
	logic [7:0]  id_len_n;
	logic [7:0]  type_n;
	logic [15:0] w_n;
	logic [15:0] h_n;
	logic [7:0]  depth_n;
	logic [8:0]  skip_n;
	logic [31:0] pix_left_n;
	logic [7:0]  pkt_left_n;
	logic        is_run_n;
	logic [31:0] col_n;
	logic [1:0]  cidx_n;

	logic        rle;
	logic        depth_ok;
	logic        img_empty;
	logic [2:0]  bpp;
	logic [31:0] col_w;
	logic        pix_done;
	logic [8:0]  pkt_count;
	logic [31:0] pix_after;
	logic [7:0]  pix_rep;
	logic [7:0]  pr, pg, pb, pa;
	logic [2:0]  pch;

	// restart mux
	always_comb begin
		if (first) begin
			ph       = PH_HEADER;
			hidx     = '0;
			id_len   = '0;
			img_type = '0;
			w        = '0;
			h        = '0;
			depth    = '0;
			skip     = '0;
			pix_left = '0;
			pkt_left = '0;
			is_run   = 1'b0;
			cidx     = '0;
		end else begin
			ph       = phase_q;
			hidx     = hidx_q;
			id_len   = id_len_q;
			img_type = type_q;
			w        = width_q;
			h        = height_q;
			depth    = depth_q;
			skip     = skip_q;
			pix_left = pix_left_q;
			pkt_left = pkt_left_q;
			is_run   = is_run_q;
			cidx     = cidx_q;
		end
	end

	// byte gathering and pixel formatting
	always_comb begin
		rle = (img_type == TYPE_RLE);
		if (depth == DEPTH_32) begin
			bpp = 3'd4;
		end else if (depth == DEPTH_24) begin
			bpp = 3'd3;
		end else begin
			bpp = 3'd2;
		end
		col_w = col_q;
		col_w[{cidx, 3'b000} +: 8] = file_byte;
		pix_done = ({1'b0, cidx} + 3'd1) >= bpp;
		if (depth == DEPTH_16) begin
			pr  = {col_w[14:10], 3'b000};
			pg  = {col_w[9:5], 3'b000};
			pb  = {col_w[4:0], 3'b000};
			pa  = 8'd0;
			pch = 3'd3;
		end else if (depth == DEPTH_32) begin
			pr  = col_w[23:16];
			pg  = col_w[15:8];
			pb  = col_w[7:0];
			pa  = col_w[31:24];
			pch = 3'd4;
		end else begin
			pr  = col_w[23:16];
			pg  = col_w[15:8];
			pb  = col_w[7:0];
			pa  = 8'd0;
			pch = 3'd3;
		end
		// packet header: raw below 128, run otherwise; clamp to what is left
		if (file_byte[7]) begin
			pkt_count = {1'b0, file_byte} - 9'd127;
		end else begin
			pkt_count = {1'b0, file_byte} + 9'd1;
		end
		if (is_run) begin
			pix_after = pix_left - {24'd0, pkt_left};
			pix_rep   = pkt_left;
		end else begin
			pix_after = pix_left - 32'd1;
			pix_rep   = 8'd1;
		end
		depth_ok  = (file_byte == DEPTH_24) || (file_byte == DEPTH_32) ||
			(!rle && (file_byte == DEPTH_16));
		img_empty = (w == 16'd0) || (h == 16'd0);
	end

	// next state and result
	always_comb begin
		ph_n       = ph;
		hidx_n     = hidx;
		id_len_n   = id_len;
		type_n     = img_type;
		w_n        = w;
		h_n        = h;
		depth_n    = depth;
		skip_n     = skip;
		pix_left_n = pix_left;
		pkt_left_n = pkt_left;
		is_run_n   = is_run;
		col_n      = col_q;
		cidx_n     = cidx;
		res_valid  = 1'b0;
		res        = '0;
		res.width  = w;
		res.height = h;
		case (ph)
			PH_HEADER: begin
				case (hidx)
					HDR_ID_LEN: id_len_n = file_byte;
					HDR_TYPE:   type_n = file_byte;
					HDR_W_LO:   w_n[7:0] = file_byte;
					HDR_W_HI:   w_n[15:8] = file_byte;
					HDR_H_LO:   h_n[7:0] = file_byte;
					HDR_H_HI:   h_n[15:8] = file_byte;
					default: ;
				endcase
				if (hidx < HDR_DEPTH) begin
					hidx_n = hidx + 5'd1;
				end else begin
					depth_n   = file_byte;
					cidx_n    = '0;
					res_valid = 1'b1;
					if (!depth_ok) begin
						ph_n     = PH_ERR;
						res.kind = KIND_ERROR;
					end else begin
						pix_left_n   = {16'd0, w} * {16'd0, h};
						skip_n       = {1'b0, id_len} + 9'd1;
						ph_n         = img_empty ? PH_DONE : PH_SKIP;
						res.kind     = KIND_HEADER;
						res.channels = (file_byte == DEPTH_32) ? 3'd4 : 3'd3;
						res.last     = img_empty;
					end
				end
			end
			PH_SKIP: begin
				skip_n = skip - 9'd1;
				if (skip == 9'd1) begin
					ph_n = rle ? PH_PKT : PH_RAW;
				end
			end
			PH_RAW, PH_PIX: begin
				col_n = col_w;
				if (!pix_done) begin
					cidx_n = cidx + 2'd1;
				end else begin
					cidx_n         = '0;
					res_valid      = 1'b1;
					res.kind       = KIND_PIXEL;
					res.channels   = pch;
					res.red        = pr;
					res.green      = pg;
					res.blue       = pb;
					res.alpha      = pa;
					res.last       = (pix_after == 32'd0);
					if (ph == PH_RAW) begin
						pix_left_n     = pix_left - 32'd1;
						res.repeat_res = 8'd1;
						res.last       = (pix_left == 32'd1);
						if (pix_left == 32'd1) begin
							ph_n = PH_DONE;
						end
					end else begin
						pix_left_n     = pix_after;
						res.repeat_res = pix_rep;
						pkt_left_n     = is_run ? 8'd0 : pkt_left - 8'd1;
						if (pix_after == 32'd0) begin
							ph_n = PH_DONE;
						end else if (is_run || pkt_left == 8'd1) begin
							ph_n = PH_PKT;
						end
					end
				end
			end
			PH_PKT: begin
				is_run_n = file_byte[7];
				if ({23'd0, pkt_count} > pix_left) begin
					pkt_left_n = pix_left[7:0];
				end else begin
					pkt_left_n = pkt_count[7:0];
				end
				ph_n = PH_PIX;
			end
			default: ;
		endcase
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hidx_q     <= '0;
			id_len_q   <= '0;
			type_q     <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			skip_q     <= '0;
			pix_left_q <= '0;
			pkt_left_q <= '0;
			is_run_q   <= 1'b0;
			cidx_q     <= '0;
		end else if (accept) begin
			phase_q    <= ph_n;
			hidx_q     <= hidx_n;
			id_len_q   <= id_len_n;
			type_q     <= type_n;
			width_q    <= w_n;
			height_q   <= h_n;
			depth_q    <= depth_n;
			skip_q     <= skip_n;
			pix_left_q <= pix_left_n;
			pkt_left_q <= pkt_left_n;
			is_run_q   <= is_run_n;
			cidx_q     <= cidx_n;
		end
	end

	// colour byte lanes, always fully rewritten before they are read
	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= col_n;
		end
	end

endmodule

>>> src/tga_image_stream_decoder.sv
// Top level of the TGA image stream decoder: parser and result register.
//
//  channel   dir  tdata                                   tuser       tlast
//  s_axis    in   file_byte[7:0]                          first[0]    -
//  m_axis    out  width,height,channels,r,g,b,a,repeat    kind[1:0]   last
//
// One file byte is taken every cycle; each byte produces at most one result.
// A result appears at m_axis in the cycle after its byte is accepted.
// The single result register sets the figure: a byte is taken whenever the
// register is empty or is being read out in the same cycle.
// arst_n clears the parse state to the start of a header.
module tga_image_stream_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [tgadec_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] file_byte
	input  logic                                 s_tuser,  // [0] first
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// [15:0] width, [31:16] height, [34:32] channels, [42:35] red,
	// [50:43] green, [58:51] blue, [66:59] alpha, [74:67] repeat_res, rest zero
	output logic [tgadec_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic [1:0]                           m_tuser,  // [1:0] kind
	output logic                                 m_tlast   // last
);
	import tgadec_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t out_q;
	logic    out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	tgadec_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.file_byte (s_tdata),
		.first     (s_tuser),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_q <= res;
		end
	end

	// output packing
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {5'd0, out_q.repeat_res, out_q.alpha, out_q.blue, out_q.green,
		out_q.red, out_q.channels, out_q.height, out_q.width};

	// an error word never completes an image
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_ERROR) |-> !m_tlast)
		else $error("error word flagged as last");

	// every pixel word covers at least one pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_PIXEL) |-> (m_tdata[74:67] != 8'd0))
		else $error("pixel word with zero repeat");

	// header and pixel words carry three or four channels
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_ERROR) |->
		(m_tdata[34:32] == 3'd3) || (m_tdata[34:32] == 3'd4))
		else $error("bad channel count");

	// a byte is only taken when the result register has room
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !out_valid_q || m_tready)
		else $error("byte accepted with result register full");

endmodule
